// ===== rtl/vmu_pkg.sv =====
// shared types, constants and helper functions of the vector math unit
package vmu_pkg;

  // operation codes
  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_NEG      = 4'd2,
    OP_SCALE    = 4'd3,
    OP_DIV      = 4'd4,
    OP_DOT      = 4'd5,
    OP_CROSS    = 4'd6,
    OP_LEN      = 4'd7,
    OP_NORM     = 4'd8,
    OP_ANGLE    = 4'd9,
    OP_LEN_SUM  = 4'd10,
    OP_LEN_DIFF = 4'd11
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SAT   = 2'd1,
    ST_UNDEF = 2'd2
  } status_e;

  // unit sizes
  localparam int SQRT_STEPS   = 32;
  localparam int CORDIC_STEPS = 28;
  localparam int DIV_STEPS    = 24;
  localparam int RAD_W        = 64;
  localparam int ROOT_W       = 32;
  localparam int CD_W         = 44;
  localparam int ZW           = 49;
  localparam int PD_W         = 48;
  localparam int NUM_W        = 52;
  localparam int DEN_W        = 28;
  localparam int QUO_W        = 24;

  // picodegree limits and 1e12 / 2^16 scaled as 5^12 after a shift by 4
  localparam logic [PD_W-1:0]  PD_90   = 48'd90000000000000;
  localparam logic [PD_W-1:0]  PD_180  = 48'd180000000000000;
  localparam logic [DEN_W-1:0] ANG_DEN = 28'd244140625;

  // item context that travels down the pipeline
  typedef struct packed {
    op_e                op;
    logic [2:0][15:0]   a;
    logic [15:0]        s;
    logic [2:0][15:0]   vec;
    logic               sat;
    logic               undef;
    logic [32:0]        scal;
    logic [ROOT_W-1:0]  root;
  } item_t;

  // clamp to q8.8
  function automatic logic [15:0] sat16(input logic signed [35:0] v);
    logic [15:0] r;
    if (v > 36'sd32767) begin
      r = 16'h7fff;
    end else if (v < -36'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // true when the value does not fit q8.8
  function automatic logic ovf16(input logic signed [35:0] v);
    return (v > 36'sd32767) || (v < -36'sd32768);
  endfunction

  // atan(2^-i) in picodegrees
  function automatic logic [PD_W-1:0] atan_pd(input logic [4:0] i);
    logic [PD_W-1:0] r;
    case (i)
      5'd0:  r = 48'd45000000000000;
      5'd1:  r = 48'd26565051177078;
      5'd2:  r = 48'd14036243467926;
      5'd3:  r = 48'd7125016348902;
      5'd4:  r = 48'd3576334374997;
      5'd5:  r = 48'd1789910608246;
      5'd6:  r = 48'd895173710211;
      5'd7:  r = 48'd447614170861;
      5'd8:  r = 48'd223810500369;
      5'd9:  r = 48'd111905677066;
      5'd10: r = 48'd55952891894;
      5'd11: r = 48'd27976452617;
      5'd12: r = 48'd13988227142;
      5'd13: r = 48'd6994113675;
      5'd14: r = 48'd3497056851;
      5'd15: r = 48'd1748528427;
      5'd16: r = 48'd874264214;
      5'd17: r = 48'd437132107;
      5'd18: r = 48'd218566053;
      5'd19: r = 48'd109283027;
      5'd20: r = 48'd54641513;
      5'd21: r = 48'd27320757;
      5'd22: r = 48'd13660378;
      5'd23: r = 48'd6830189;
      5'd24: r = 48'd3415095;
      5'd25: r = 48'd1707547;
      5'd26: r = 48'd853774;
      5'd27: r = 48'd426887;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/vmu_front.sv =====
// front stages: products, sums, cross squares and square root radicand
module vmu_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  vmu_pkg::item_t             item_i,
  input  logic [2:0][15:0]           b_i,
  output logic                       valid_o,
  output vmu_pkg::item_t             item_o,
  output logic [vmu_pkg::RAD_W-1:0]  rad_o
);

  logic                    v1_q, v2_q, v3_q, v4_q, v5_q;
  vmu_pkg::item_t          it1_q, it2_q, it3_q, it4_q, it5_q;
  vmu_pkg::item_t          it2_d, it3_d;
  logic [2:0][15:0]        b1_q;
  logic signed [16:0]      ax [3];
  logic signed [16:0]      bx [3];
  logic signed [16:0]      ma [3];
  logic signed [16:0]      mb [3];
  logic signed [35:0]      e2 [3];
  logic signed [33:0]      p_d [3];
  logic signed [33:0]      p2_q [3];
  logic signed [31:0]      pc_d [6];
  logic signed [31:0]      pc2_q [6];
  logic signed [35:0]      psum_d, psum3_q, psum4_q;
  logic signed [32:0]      c_d [3];
  logic signed [32:0]      c3_q [3];
  logic signed [33:0]      sc_t [3];
  logic signed [32:0]      cr_t [3];
  logic signed [32:0]      cmag [3];
  logic [63:0]             cq_d [3];
  logic [63:0]             cq4_q [3];
  logic [vmu_pkg::RAD_W-1:0] rad_d, rad5_q;

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // stage 1: capture the item
  always_ff @(posedge clk_i) begin
    it1_q <= item_i;
    b1_q  <= b_i;
  end

  // stage 2: multiplier operands, products, simple vector ops, undefined cases
  always_comb begin
    it2_d = it1_q;
    for (int i = 0; i < 3; i++) begin
      ax[i] = 17'($signed(it1_q.a[i]));
      bx[i] = 17'($signed(b1_q[i]));
    end
    for (int i = 0; i < 3; i++) begin
      case (it1_q.op) inside
        vmu_pkg::OP_SCALE: begin
          ma[i] = ax[i];
          mb[i] = 17'($signed(it1_q.s));
        end
        vmu_pkg::OP_LEN, vmu_pkg::OP_NORM: begin
          ma[i] = ax[i];
          mb[i] = ax[i];
        end
        vmu_pkg::OP_LEN_SUM: begin
          ma[i] = ax[i] + bx[i];
          mb[i] = ax[i] + bx[i];
        end
        vmu_pkg::OP_LEN_DIFF: begin
          ma[i] = ax[i] - bx[i];
          mb[i] = ax[i] - bx[i];
        end
        default: begin
          ma[i] = ax[i];
          mb[i] = bx[i];
        end
      endcase
      p_d[i] = ma[i] * mb[i];
      case (it1_q.op) inside
        vmu_pkg::OP_ADD: e2[i] = 36'(ax[i]) + 36'(bx[i]);
        vmu_pkg::OP_SUB: e2[i] = 36'(ax[i]) - 36'(bx[i]);
        vmu_pkg::OP_NEG: e2[i] = -36'(ax[i]);
        default:         e2[i] = '0;
      endcase
      it2_d.vec[i] = vmu_pkg::sat16(e2[i]);
    end
    pc_d[0] = ax[1] * bx[2];
    pc_d[1] = ax[2] * bx[1];
    pc_d[2] = ax[2] * bx[0];
    pc_d[3] = ax[0] * bx[2];
    pc_d[4] = ax[0] * bx[1];
    pc_d[5] = ax[1] * bx[0];
    it2_d.sat = vmu_pkg::ovf16(e2[0]) | vmu_pkg::ovf16(e2[1]) | vmu_pkg::ovf16(e2[2]);
    case (it1_q.op) inside
      vmu_pkg::OP_DIV:   it2_d.undef = (it1_q.s == '0);
      vmu_pkg::OP_NORM:  it2_d.undef = (it1_q.a == '0);
      vmu_pkg::OP_ANGLE: it2_d.undef = (it1_q.a == '0) || (b1_q == '0);
      vmu_pkg::OP_ADD, vmu_pkg::OP_SUB, vmu_pkg::OP_NEG, vmu_pkg::OP_SCALE,
      vmu_pkg::OP_DOT, vmu_pkg::OP_CROSS, vmu_pkg::OP_LEN, vmu_pkg::OP_LEN_SUM,
      vmu_pkg::OP_LEN_DIFF: it2_d.undef = 1'b0;
      default:           it2_d.undef = 1'b1;
    endcase
    it2_d.scal = '0;
    it2_d.root = '0;
  end

  always_ff @(posedge clk_i) begin
    it2_q <= it2_d;
    p2_q  <= p_d;
    pc2_q <= pc_d;
  end

  // stage 3: product sums, cross components, scale and cross results
  always_comb begin
    it3_d  = it2_q;
    psum_d = 36'(p2_q[0]) + 36'(p2_q[1]) + 36'(p2_q[2]);
    c_d[0] = 33'(pc2_q[0]) - 33'(pc2_q[1]);
    c_d[1] = 33'(pc2_q[2]) - 33'(pc2_q[3]);
    c_d[2] = 33'(pc2_q[4]) - 33'(pc2_q[5]);
    for (int i = 0; i < 3; i++) begin
      sc_t[i] = (p2_q[i] + (p2_q[i][33] ? 34'sd255 : 34'sd0)) >>> 8;
      cr_t[i] = (c_d[i] + (c_d[i][32] ? 33'sd255 : 33'sd0)) >>> 8;
    end
    case (it2_q.op) inside
      vmu_pkg::OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          it3_d.vec[i] = vmu_pkg::sat16(36'(sc_t[i]));
        end
        it3_d.sat = vmu_pkg::ovf16(36'(sc_t[0])) | vmu_pkg::ovf16(36'(sc_t[1])) |
                    vmu_pkg::ovf16(36'(sc_t[2]));
      end
      vmu_pkg::OP_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          it3_d.vec[i] = vmu_pkg::sat16(36'(cr_t[i]));
        end
        it3_d.sat = vmu_pkg::ovf16(36'(cr_t[0])) | vmu_pkg::ovf16(36'(cr_t[1])) |
                    vmu_pkg::ovf16(36'(cr_t[2]));
      end
      vmu_pkg::OP_DOT, vmu_pkg::OP_ANGLE: begin
        it3_d.scal = psum_d[32:0];
      end
      default: begin
        it3_d.scal = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    it3_q   <= it3_d;
    psum3_q <= psum_d;
    c3_q    <= c_d;
  end

  // stage 4: squares of the cross components
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cmag[i] = c3_q[i][32] ? -c3_q[i] : c3_q[i];
      cq_d[i] = 64'(cmag[i][31:0]) * 64'(cmag[i][31:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    it4_q   <= it3_q;
    psum4_q <= psum3_q;
    cq4_q   <= cq_d;
  end

  // stage 5: radicand for the square root
  always_comb begin
    case (it4_q.op) inside
      vmu_pkg::OP_ANGLE: rad_d = cq4_q[0] + cq4_q[1] + cq4_q[2];
      vmu_pkg::OP_LEN, vmu_pkg::OP_NORM, vmu_pkg::OP_LEN_SUM, vmu_pkg::OP_LEN_DIFF:
        rad_d = {14'b0, psum4_q[33:0], 16'b0};
      default: rad_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    it5_q  <= it4_q;
    rad5_q <= rad_d;
  end

  assign valid_o = v5_q;
  assign item_o  = it5_q;
  assign rad_o   = rad5_q;

endmodule

// ===== rtl/vmu_sqrt.sv =====
// pipelined integer square root, one result bit per stage
module vmu_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  vmu_pkg::item_t             item_i,
  input  logic [vmu_pkg::RAD_W-1:0]  rad_i,
  output logic                       valid_o,
  output vmu_pkg::item_t             item_o
);

  localparam int S = vmu_pkg::SQRT_STEPS;

  logic [S-1:0]               v_q;
  vmu_pkg::item_t             it_q [S];
  logic [vmu_pkg::RAD_W-1:0]  n_q  [S];
  logic [vmu_pkg::RAD_W-1:0]  r_q  [S];

  for (genvar k = 0; k < S; k++) begin : g_st
    localparam logic [vmu_pkg::RAD_W-1:0] STEP_BIT = 64'(1) << (62 - 2 * k);
    logic                       v_in;
    vmu_pkg::item_t             it_in;
    logic [vmu_pkg::RAD_W-1:0]  n_in, r_in, trial, n_d, r_d;

    if (k == 0) begin : g_first
      assign v_in  = valid_i;
      assign it_in = item_i;
      assign n_in  = rad_i;
      assign r_in  = '0;
    end else begin : g_next
      assign v_in  = v_q[k-1];
      assign it_in = it_q[k-1];
      assign n_in  = n_q[k-1];
      assign r_in  = r_q[k-1];
    end

    // one trial subtraction
    always_comb begin
      trial = r_in + STEP_BIT;
      if (n_in >= trial) begin
        n_d = n_in - trial;
        r_d = (r_in >> 1) + STEP_BIT;
      end else begin
        n_d = n_in;
        r_d = r_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      it_q[k] <= it_in;
      n_q[k]  <= n_d;
      r_q[k]  <= r_d;
    end
  end

  // root joins the item
  always_comb begin
    item_o      = it_q[S-1];
    item_o.root = r_q[S-1][vmu_pkg::ROOT_W-1:0];
  end

  assign valid_o = v_q[S-1];

endmodule

// ===== rtl/vmu_cordic.sv =====
// angle of (|dot|, |cross|) by a vectoring cordic in picodegrees, folded to 0..180 by the dot sign
module vmu_cordic (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  vmu_pkg::item_t            item_i,
  output logic                      valid_o,
  output vmu_pkg::item_t            item_o,
  output logic [vmu_pkg::PD_W-1:0]  pd_o
);

  localparam int S  = vmu_pkg::CORDIC_STEPS;
  localparam int XW = vmu_pkg::CD_W;
  localparam int ZW = vmu_pkg::ZW;

  logic                  n1v_q, n2v_q, fv_q;
  vmu_pkg::item_t        n1it_q, n2it_q, fit_q;
  logic                  n1neg_q, n2neg_q;
  logic [XW-1:0]         n1x_q, n1y_q, n2x_q, n2y_q;
  logic [XW-1:0]         xa, ya, xb, yb;
  logic signed [32:0]    dsig, dmag;
  logic [S-1:0]          v_q;
  vmu_pkg::item_t        it_q  [S];
  logic [S-1:0]          neg_q;
  logic signed [XW-1:0]  x_q   [S];
  logic signed [XW-1:0]  y_q   [S];
  logic signed [ZW-1:0]  z_q   [S];
  logic signed [ZW-1:0]  zl;
  logic [vmu_pkg::PD_W-1:0] zc, pd_d, pd_q;

  // coarse normalization: shift by 32, 16, 8
  always_comb begin
    dsig = $signed(item_i.scal);
    dmag = dsig[32] ? -dsig : dsig;
    xa   = XW'(dmag[31:0]);
    ya   = XW'(item_i.root);
    for (int j = 0; j < 3; j++) begin
      if (((xa | ya) >> (41 - (32 >> j))) == '0) begin
        xa = xa << (32 >> j);
        ya = ya << (32 >> j);
      end
    end
  end

  // fine normalization: shift by 4, 2, 1
  always_comb begin
    xb = n1x_q;
    yb = n1y_q;
    for (int j = 0; j < 3; j++) begin
      if (((xb | yb) >> (41 - (4 >> j))) == '0) begin
        xb = xb << (4 >> j);
        yb = yb << (4 >> j);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n1v_q <= 1'b0;
      n2v_q <= 1'b0;
      fv_q  <= 1'b0;
    end else begin
      n1v_q <= valid_i;
      n2v_q <= n1v_q;
      fv_q  <= v_q[S-1];
    end
  end

  always_ff @(posedge clk_i) begin
    n1it_q  <= item_i;
    n1neg_q <= dsig[32];
    n1x_q   <= xa;
    n1y_q   <= ya;
    n2it_q  <= n1it_q;
    n2neg_q <= n1neg_q;
    n2x_q   <= xb;
    n2y_q   <= yb;
  end

  // rotation stages
  for (genvar k = 0; k < S; k++) begin : g_it
    localparam logic signed [ZW-1:0] ATAN_K = $signed({1'b0, vmu_pkg::atan_pd(5'(k))});
    logic                  v_in, neg_in;
    vmu_pkg::item_t        it_in;
    logic signed [XW-1:0]  x_in, y_in, xs, ys, x_d, y_d;
    logic signed [ZW-1:0]  z_in, z_d;

    if (k == 0) begin : g_first
      assign v_in   = n2v_q;
      assign it_in  = n2it_q;
      assign neg_in = n2neg_q;
      assign x_in   = $signed(n2x_q);
      assign y_in   = $signed(n2y_q);
      assign z_in   = '0;
    end else begin : g_next
      assign v_in   = v_q[k-1];
      assign it_in  = it_q[k-1];
      assign neg_in = neg_q[k-1];
      assign x_in   = x_q[k-1];
      assign y_in   = y_q[k-1];
      assign z_in   = z_q[k-1];
    end

    // shifts round toward zero
    always_comb begin
      xs = x_in >>> k;
      ys = y_in[XW-1] ? -((-y_in) >>> k) : (y_in >>> k);
      if (y_in > 0) begin
        x_d = x_in + ys;
        y_d = y_in - xs;
        z_d = z_in + ATAN_K;
      end else if (y_in < 0) begin
        x_d = x_in - ys;
        y_d = y_in + xs;
        z_d = z_in - ATAN_K;
      end else begin
        x_d = x_in;
        y_d = y_in;
        z_d = z_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      it_q[k]  <= it_in;
      neg_q[k] <= neg_in;
      x_q[k]   <= x_d;
      y_q[k]   <= y_d;
      z_q[k]   <= z_d;
    end
  end

  // clamp to 0..90 and fold into 0..180
  always_comb begin
    zl = z_q[S-1];
    if (zl < 0) begin
      zc = '0;
    end else if (zl > $signed({1'b0, vmu_pkg::PD_90})) begin
      zc = vmu_pkg::PD_90;
    end else begin
      zc = zl[vmu_pkg::PD_W-1:0];
    end
    pd_d = neg_q[S-1] ? (vmu_pkg::PD_180 - zc) : zc;
  end

  always_ff @(posedge clk_i) begin
    fit_q <= it_q[S-1];
    pd_q  <= pd_d;
  end

  assign valid_o = fv_q;
  assign item_o  = fit_q;
  assign pd_o    = pd_q;

endmodule

// ===== rtl/vmu_div.sv =====
// three lane restoring divider, one quotient bit per stage
module vmu_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  vmu_pkg::item_t                      item_i,
  input  logic [vmu_pkg::PD_W-1:0]            pd_i,
  output logic                                valid_o,
  output vmu_pkg::item_t                      item_o,
  output logic [2:0][vmu_pkg::QUO_W-1:0]      quo_o,
  output logic [2:0]                          neg_o
);

  localparam int S  = vmu_pkg::DIV_STEPS;
  localparam int NW = vmu_pkg::NUM_W;
  localparam int DW = vmu_pkg::DEN_W;
  localparam int QW = vmu_pkg::QUO_W;

  logic signed [16:0]      as [3];
  logic signed [16:0]      ss;
  logic [16:0]             amag [3];
  logic [16:0]             smag;
  logic [NW-1:0]           num [3];
  logic [DW-1:0]           den_d;
  logic [2:0]              neg_d;
  logic [S:0]              v_q;
  vmu_pkg::item_t          it_q  [S+1];
  logic [2:0]              neg_q [S+1];
  logic [DW-1:0]           den_q [S+1];
  logic [DW-1:0]           rem_q [S+1][3];
  logic [QW-1:0]           low_q [S+1][3];
  logic [QW-1:0]           q_q   [S+1][3];

  // operand setup per operation
  always_comb begin
    ss   = 17'($signed(item_i.s));
    smag = ss[16] ? 17'(-ss) : 17'(ss);
    for (int i = 0; i < 3; i++) begin
      as[i]   = 17'($signed(item_i.a[i]));
      amag[i] = as[i][16] ? 17'(-as[i]) : 17'(as[i]);
    end
    case (item_i.op) inside
      vmu_pkg::OP_DIV: begin
        for (int i = 0; i < 3; i++) begin
          num[i]   = NW'(amag[i]) << 8;
          neg_d[i] = as[i][16] ^ ss[16];
        end
        den_d = DW'(smag);
      end
      vmu_pkg::OP_NORM: begin
        for (int i = 0; i < 3; i++) begin
          num[i]   = NW'(amag[i]) << 16;
          neg_d[i] = as[i][16];
        end
        den_d = item_i.root[DW-1:0];
      end
      vmu_pkg::OP_ANGLE: begin
        num[0] = {pd_i, 4'b0};
        num[1] = '0;
        num[2] = '0;
        neg_d  = '0;
        den_d  = vmu_pkg::ANG_DEN;
      end
      default: begin
        for (int i = 0; i < 3; i++) begin
          num[i] = '0;
        end
        neg_d = '0;
        den_d = vmu_pkg::ANG_DEN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    it_q[0]  <= item_i;
    neg_q[0] <= neg_d;
    den_q[0] <= den_d;
    for (int i = 0; i < 3; i++) begin
      rem_q[0][i] <= num[i][NW-1:QW];
      low_q[0][i] <= num[i][QW-1:0];
      q_q[0][i]   <= '0;
    end
  end

  // quotient bit stages
  for (genvar k = 1; k <= S; k++) begin : g_st
    logic [DW:0]    t   [3];
    logic           ge  [3];
    logic [DW-1:0]  r_d [3];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t[i]   = {rem_q[k-1][i], low_q[k-1][i][QW-1]};
        ge[i]  = (t[i] >= {1'b0, den_q[k-1]});
        r_d[i] = ge[i] ? DW'(t[i] - {1'b0, den_q[k-1]}) : t[i][DW-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      it_q[k]  <= it_q[k-1];
      neg_q[k] <= neg_q[k-1];
      den_q[k] <= den_q[k-1];
      for (int i = 0; i < 3; i++) begin
        rem_q[k][i] <= r_d[i];
        low_q[k][i] <= low_q[k-1][i] << 1;
        q_q[k][i]   <= {q_q[k-1][i][QW-2:0], ge[i]};
      end
    end
  end

  assign valid_o = v_q[S];
  assign item_o  = it_q[S];
  assign neg_o   = neg_q[S];
  assign quo_o   = {q_q[S][2], q_q[S][1], q_q[S][0]};

endmodule

// ===== rtl/vector3_math_unit.sv =====
// top level: pipelined three-component vector alu with q8.8 vectors and q16.16 scalars
// throughput: one item per cycle; busy stays low, start may be high in every cycle
// latency is set by the 32-step square root, 28-step cordic and 24-step divider
// results are strobed for one cycle on done_o and cannot be held off
// reset clears only the valid bits; items in flight are dropped
module vector3_math_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         kind_i,
  input  logic signed [15:0] a_x_i,
  input  logic signed [15:0] a_y_i,
  input  logic signed [15:0] a_z_i,
  input  logic signed [15:0] b_x_i,
  input  logic signed [15:0] b_y_i,
  input  logic signed [15:0] b_z_i,
  input  logic signed [15:0] scalar_i,
  output logic               done_o,
  output logic signed [15:0] out_x_o,
  output logic signed [15:0] out_y_o,
  output logic signed [15:0] out_z_o,
  output logic signed [32:0] out_scalar_o,
  output logic [1:0]         status_o
);

  vmu_pkg::item_t                     in_item, fr_item, sq_item, cd_item, dv_item;
  logic                               fr_valid, sq_valid, cd_valid, dv_valid;
  logic [vmu_pkg::RAD_W-1:0]          fr_rad;
  logic [vmu_pkg::PD_W-1:0]           cd_pd;
  logic [2:0][vmu_pkg::QUO_W-1:0]     dv_quo;
  logic [2:0]                         dv_neg;
  logic signed [35:0]                 qs [3];
  logic [2:0][15:0]                   vec_d;
  logic [32:0]                        scal_d;
  vmu_pkg::status_e                   st_d, st_q;
  logic                               done_q;
  logic [15:0]                        x_q, y_q, z_q;
  logic [32:0]                        scal_q;

  assign busy = 1'b0;

  // pack the incoming item
  always_comb begin
    in_item      = '0;
    in_item.op   = vmu_pkg::op_e'(kind_i);
    in_item.a    = {a_z_i, a_y_i, a_x_i};
    in_item.s    = scalar_i;
  end

  vmu_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start & ~busy),
    .item_i  (in_item),
    .b_i     ({b_z_i, b_y_i, b_x_i}),
    .valid_o (fr_valid),
    .item_o  (fr_item),
    .rad_o   (fr_rad)
  );

  vmu_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid),
    .item_i  (fr_item),
    .rad_i   (fr_rad),
    .valid_o (sq_valid),
    .item_o  (sq_item)
  );

  vmu_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_valid),
    .item_i  (sq_item),
    .valid_o (cd_valid),
    .item_o  (cd_item),
    .pd_o    (cd_pd)
  );

  vmu_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cd_valid),
    .item_i  (cd_item),
    .pd_i    (cd_pd),
    .valid_o (dv_valid),
    .item_o  (dv_item),
    .quo_o   (dv_quo),
    .neg_o   (dv_neg)
  );

  // result assembly
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qs[i] = dv_neg[i] ? -$signed({12'b0, dv_quo[i]}) : $signed({12'b0, dv_quo[i]});
    end
    vec_d  = '0;
    scal_d = '0;
    st_d   = vmu_pkg::ST_OK;
    case (dv_item.op) inside
      vmu_pkg::OP_ADD, vmu_pkg::OP_SUB, vmu_pkg::OP_NEG, vmu_pkg::OP_SCALE,
      vmu_pkg::OP_CROSS: begin
        vec_d = dv_item.vec;
        st_d  = dv_item.sat ? vmu_pkg::ST_SAT : vmu_pkg::ST_OK;
      end
      vmu_pkg::OP_DIV, vmu_pkg::OP_NORM: begin
        if (dv_item.undef) begin
          st_d = vmu_pkg::ST_UNDEF;
        end else begin
          for (int i = 0; i < 3; i++) begin
            vec_d[i] = vmu_pkg::sat16(qs[i]);
          end
          if (vmu_pkg::ovf16(qs[0]) || vmu_pkg::ovf16(qs[1]) || vmu_pkg::ovf16(qs[2])) begin
            st_d = vmu_pkg::ST_SAT;
          end
        end
      end
      vmu_pkg::OP_DOT: begin
        scal_d = dv_item.scal;
      end
      vmu_pkg::OP_LEN, vmu_pkg::OP_LEN_SUM, vmu_pkg::OP_LEN_DIFF: begin
        scal_d = {1'b0, dv_item.root};
      end
      vmu_pkg::OP_ANGLE: begin
        if (dv_item.undef) begin
          st_d = vmu_pkg::ST_UNDEF;
        end else begin
          scal_d = 33'(dv_quo[0]);
        end
      end
      default: begin
        st_d = vmu_pkg::ST_UNDEF;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= vec_d[0];
    y_q    <= vec_d[1];
    z_q    <= vec_d[2];
    scal_q <= scal_d;
    st_q   <= st_d;
  end

  assign done_o       = done_q;
  assign out_x_o      = $signed(x_q);
  assign out_y_o      = $signed(y_q);
  assign out_z_o      = $signed(z_q);
  assign out_scalar_o = $signed(scal_q);
  assign status_o     = st_q;

endmodule
